// ===== hw/rtl/nvec_pkg.sv =====
// ----------------------------------------------------------------------------
// nvec_pkg
// Shared types and constants for the 3D vector normalization block.
// ----------------------------------------------------------------------------
`default_nettype none

package nvec_pkg;

  // Field widths of the input components and of the Q1.F results.
  localparam int COMPONENT_WIDTH = 16;
  localparam int FRACTION_BITS   = 14;
  localparam int OUT_WIDTH       = FRACTION_BITS + 2;

  // Internal widths: squares, sum of squares, residual arithmetic.
  localparam int SQ_WIDTH   = 2 * COMPONENT_WIDTH;
  localparam int SUM_WIDTH  = 2 * COMPONENT_WIDTH + 2;
  localparam int DIFF_WIDTH = 2 * COMPONENT_WIDTH + 2 * FRACTION_BITS + 4;
  localparam int LANES      = 3;
  localparam int NUM_CELLS  = FRACTION_BITS + 1;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] x_in;
    logic signed [COMPONENT_WIDTH-1:0] y_in;
    logic signed [COMPONENT_WIDTH-1:0] z_in;
  } vec_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] x_unit;
    logic signed [OUT_WIDTH-1:0] y_unit;
    logic signed [OUT_WIDTH-1:0] z_unit;
    logic                        zero_length;
  } unit_t;

  // Control that travels with every transaction along the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/normalize_3d_vector_top.sv =====
// ----------------------------------------------------------------------------
// normalize_3d_vector_top
// Unit vector of a signed 3D integer vector in signed Q1.14, truncated
// toward zero, with a flag for the zero vector.
//
//   Channel  Valid       Stall       Payload
//   input    vec_valid   vec_stall   vec  (x_in, y_in, z_in)
//   output   unit_valid  unit_stall  unit (x_unit, y_unit, z_unit, zero_length)
//
// One transaction per cycle while the output is not stalled; the pipeline has two
// front stages, one cell per result bit (15 cells), and the output register.
// Reset empties every stage; payload registers are not reset.
// Each stage moves when empty or when the next one moves, so bubbles close
// up under a stall and input is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module normalize_3d_vector_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vec_valid,
  output logic                 vec_stall,
  input  wire nvec_pkg::vec_t  vec,
  output logic                 unit_valid,
  input  wire logic            unit_stall,
  output nvec_pkg::unit_t      unit
);

  localparam int NC = nvec_pkg::NUM_CELLS;
  localparam int OW = nvec_pkg::OUT_WIDTH;

  logic signed [nvec_pkg::COMPONENT_WIDTH-1:0] comp [nvec_pkg::LANES];
  nvec_pkg::ctl_t ctl_s [NC+1];
  logic [nvec_pkg::LANES-1:0] neg_s [NC+1];
  logic [nvec_pkg::SUM_WIDTH-1:0] sum_s [NC+1];
  logic [nvec_pkg::DIFF_WIDTH-1:0] r_s [NC+1][nvec_pkg::LANES];
  logic [nvec_pkg::DIFF_WIDTH-1:0] p_s [NC+1][nvec_pkg::LANES];
  logic [OW-1:0] q_s [NC+1][nvec_pkg::LANES];
  logic en_s [NC+1];
  logic en_out;
  logic [OW-1:0] res [nvec_pkg::LANES];
  logic vec_stall_n;

  assign comp[0] = vec.x_in;
  assign comp[1] = vec.y_in;
  assign comp[2] = vec.z_in;

  // Front stages: squares, sum and initial residuals.
  nvec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_in (vec_valid),
    .comp     (comp),
    .en_down  (en_s[0]),
    .en_up    (vec_stall_n),
    .ctl_out  (ctl_s[0]),
    .neg_out  (neg_s[0]),
    .sum_out  (sum_s[0]),
    .r_out    (r_s[0])
  );

  assign vec_stall = !vec_stall_n;

  // Chain starts with zero product and zero quotient bits.
  always_comb begin
    for (int i = 0; i < nvec_pkg::LANES; i++) begin
      p_s[0][i] = '0;
      q_s[0][i] = '0;
    end
  end

  // One cell per result bit, most significant first.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    nvec_cell #(.BIT(nvec_pkg::FRACTION_BITS - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[k]),
      .neg_in  (neg_s[k]),
      .sum_in  (sum_s[k]),
      .r_in    (r_s[k]),
      .p_in    (p_s[k]),
      .q_in    (q_s[k]),
      .en_down (en_s[k+1]),
      .en_up   (en_s[k]),
      .ctl_out (ctl_s[k+1]),
      .neg_out (neg_s[k+1]),
      .sum_out (sum_s[k+1]),
      .r_out   (r_s[k+1]),
      .p_out   (p_s[k+1]),
      .q_out   (q_s[k+1])
    );
  end

  assign en_out  = !unit_valid || !unit_stall;
  assign en_s[NC] = en_out;

  // Apply the sign; the zero vector forces zero outputs.
  always_comb begin
    for (int i = 0; i < nvec_pkg::LANES; i++) begin
      if (ctl_s[NC].zero) begin
        res[i] = '0;
      end else if (neg_s[NC][i]) begin
        res[i] = OW'(-q_s[NC][i]);
      end else begin
        res[i] = q_s[NC][i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (en_out) begin
      unit_valid <= ctl_s[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      unit.x_unit      <= $signed(res[0]);
      unit.y_unit      <= $signed(res[1]);
      unit.z_unit      <= $signed(res[2]);
      unit.zero_length <= ctl_s[NC].zero;
    end
  end

  // A zero vector always reports zero components.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit.zero_length |->
      unit.x_unit == '0 && unit.y_unit == '0 && unit.z_unit == '0)
    else $error("zero vector with nonzero components");

  // Every component lies within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    unit_valid |->
      unit.x_unit <= 16'sd16384 && unit.x_unit >= -16'sd16384 &&
      unit.y_unit <= 16'sd16384 && unit.y_unit >= -16'sd16384 &&
      unit.z_unit <= 16'sd16384 && unit.z_unit >= -16'sd16384)
    else $error("unit component out of range");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !unit_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/nvec_front.sv =====
// ----------------------------------------------------------------------------
// nvec_front
// Two pipeline stages: component magnitudes and squares, then the sum of
// squares and the initial residual of each lane.
// ----------------------------------------------------------------------------
`default_nettype none

module nvec_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_in,
  input  wire logic signed [nvec_pkg::COMPONENT_WIDTH-1:0] comp [nvec_pkg::LANES],
  input  wire logic en_down,
  output logic      en_up,
  output nvec_pkg::ctl_t ctl_out,
  output logic [nvec_pkg::LANES-1:0] neg_out,
  output logic [nvec_pkg::SUM_WIDTH-1:0] sum_out,
  output logic [nvec_pkg::DIFF_WIDTH-1:0] r_out [nvec_pkg::LANES]
);

  localparam int CW = nvec_pkg::COMPONENT_WIDTH;

  logic v1;
  logic v2;
  logic en1;
  logic en2;
  logic zero1;
  logic zero2;
  logic [nvec_pkg::LANES-1:0] neg1;
  logic [nvec_pkg::LANES-1:0] neg2;
  logic [nvec_pkg::SQ_WIDTH-1:0] sq1 [nvec_pkg::LANES];
  logic [CW-1:0] mag [nvec_pkg::LANES];
  logic [nvec_pkg::SUM_WIDTH-1:0] sum2;
  logic [nvec_pkg::DIFF_WIDTH-1:0] r2 [nvec_pkg::LANES];

  // A stage moves when it is empty or its successor moves.
  assign en2   = !v2 || en_down;
  assign en1   = !v1 || en2;
  assign en_up = en1;

  // Magnitude of each component; the most negative value maps to 2^(CW-1).
  always_comb begin
    for (int i = 0; i < nvec_pkg::LANES; i++) begin
      mag[i] = comp[i][CW-1] ? CW'(-comp[i]) : CW'(comp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= valid_in;
      if (en2) v2 <= v1;
    end
  end

  // Stage one: squares of the magnitudes.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < nvec_pkg::LANES; i++) begin
        sq1[i]  <= mag[i] * mag[i];
        neg1[i] <= comp[i][CW-1];
      end
      zero1 <= (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
    end
  end

  // Stage two: sum of squares and residual c*c*2^(2F) per lane.
  always_ff @(posedge clk) begin
    if (en2) begin
      sum2 <= nvec_pkg::SUM_WIDTH'(sq1[0]) + nvec_pkg::SUM_WIDTH'(sq1[1])
            + nvec_pkg::SUM_WIDTH'(sq1[2]);
      for (int i = 0; i < nvec_pkg::LANES; i++) begin
        r2[i] <= nvec_pkg::DIFF_WIDTH'(sq1[i]) << (2 * nvec_pkg::FRACTION_BITS);
      end
      neg2  <= neg1;
      zero2 <= zero1;
    end
  end

  assign ctl_out.valid = v2;
  assign ctl_out.zero  = zero2;
  assign neg_out       = neg2;
  assign sum_out       = sum2;
  assign r_out         = r2;

endmodule

`default_nettype wire

// ===== hw/rtl/nvec_cell.sv =====
// ----------------------------------------------------------------------------
// nvec_cell
// One cell of the result chain. It decides bit BIT of the unit magnitude of
// all three lanes by a residual compare, and hands its state to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module nvec_cell #(
  parameter int BIT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire nvec_pkg::ctl_t ctl_in,
  input  wire logic [nvec_pkg::LANES-1:0] neg_in,
  input  wire logic [nvec_pkg::SUM_WIDTH-1:0] sum_in,
  input  wire logic [nvec_pkg::DIFF_WIDTH-1:0] r_in [nvec_pkg::LANES],
  input  wire logic [nvec_pkg::DIFF_WIDTH-1:0] p_in [nvec_pkg::LANES],
  input  wire logic [nvec_pkg::OUT_WIDTH-1:0] q_in [nvec_pkg::LANES],
  input  wire logic en_down,
  output logic      en_up,
  output nvec_pkg::ctl_t ctl_out,
  output logic [nvec_pkg::LANES-1:0] neg_out,
  output logic [nvec_pkg::SUM_WIDTH-1:0] sum_out,
  output logic [nvec_pkg::DIFF_WIDTH-1:0] r_out [nvec_pkg::LANES],
  output logic [nvec_pkg::DIFF_WIDTH-1:0] p_out [nvec_pkg::LANES],
  output logic [nvec_pkg::OUT_WIDTH-1:0] q_out [nvec_pkg::LANES]
);

  localparam int DW = nvec_pkg::DIFF_WIDTH;

  logic [DW-1:0] sum_w;
  logic [DW-1:0] d [nvec_pkg::LANES];
  logic [nvec_pkg::LANES-1:0] take;

  assign en_up = !ctl_out.valid || en_down;
  assign sum_w = DW'(sum_in);

  // Setting the bit adds (2^(BIT+1)*q + 2^(2*BIT))*sum to q*q*sum, where
  // p holds q*sum; the bit stays when that fits in the residual.
  always_comb begin
    for (int i = 0; i < nvec_pkg::LANES; i++) begin
      d[i]    = (p_in[i] << (BIT + 1)) + (sum_w << (2 * BIT));
      take[i] = d[i] <= r_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en_up) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      ctl_out.zero <= ctl_in.zero;
      neg_out      <= neg_in;
      sum_out      <= sum_in;
      for (int i = 0; i < nvec_pkg::LANES; i++) begin
        r_out[i] <= take[i] ? r_in[i] - d[i] : r_in[i];
        p_out[i] <= take[i] ? p_in[i] + (sum_w << BIT) : p_in[i];
        q_out[i] <= take[i] ? q_in[i] | (nvec_pkg::OUT_WIDTH'(1) << BIT) : q_in[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for normalize_3d_vector_top. Vectors are sent through the
// valid/stall input channel with random gaps, results are taken with random
// stalls, and every result is checked against a bit-exact predictor that
// finds each normalized component by a restoring bit search.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 18;
  localparam int STALL_LIMIT = 5000;
  localparam int CW          = nvec_pkg::COMPONENT_WIDTH;
  localparam int OW          = nvec_pkg::OUT_WIDTH;
  localparam int FB          = nvec_pkg::FRACTION_BITS;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  vec_valid = 1'b0;
  logic  vec_stall;
  nvec_pkg::vec_t  vec = '0;
  logic  unit_valid;
  logic  unit_stall = 1'b0;
  nvec_pkg::unit_t unit;

  nvec_pkg::unit_t pending_units[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    checker_on = 1'b0;

  always #1 clk = ~clk;

  normalize_3d_vector_top i_dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .unit_valid(unit_valid), .unit_stall(unit_stall), .unit(unit)
  );

  // Largest q with q*q*sum <= mag*mag*2^(2F), then signed by the input.
  function automatic logic signed [OW-1:0] unit_component(
      logic signed [CW-1:0] c, logic [63:0] sum);
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic [63:0]  t;
    mag = c[CW-1] ? 64'(-$signed(64'(c))) : 64'(c);
    rhs = 128'(mag * mag) << (2 * FB);
    q = 0;
    for (int b = FB; b >= 0; b--) begin
      t = q | (64'd1 << b);
      lhs = 128'(t * t) * 128'(sum);
      if (lhs <= rhs) q = t;
    end
    if (c[CW-1]) q = -q;
    return q[OW-1:0];
  endfunction

  function automatic nvec_pkg::unit_t normalize(nvec_pkg::vec_t v);
    nvec_pkg::unit_t r;
    logic [63:0] sum;
    sum = 64'($signed(v.x_in) * $signed(v.x_in)) + 64'($signed(v.y_in) * $signed(v.y_in))
        + 64'($signed(v.z_in) * $signed(v.z_in));
    r = '0;
    if (sum == 0) begin
      r.zero_length = 1'b1;
    end else begin
      r.x_unit = unit_component(v.x_in, sum);
      r.y_unit = unit_component(v.y_in, sum);
      r.z_unit = unit_component(v.z_in, sum);
    end
    return r;
  endfunction

  // Send one vector after a random gap and record its expected result.
  // Valid stays high between back-to-back transactions.
  task automatic send_vector(nvec_pkg::vec_t v);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
    if (gap > 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec       <= v;
    vec_valid <= 1'b1;
    do @(posedge clk); while (vec_stall);
    pending_units.push_back(normalize(v));
  endtask

  // Drop valid after the last accepted transaction.
  task automatic idle_sender();
    vec_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_component();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(7)) - 16'sd3;
      3: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] ext[6] = '{16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd0, 16'sd12345};
    send_vector('{16'sd0, 16'sd0, 16'sd0});
    send_vector('{16'sh7fff, 16'sd0, 16'sd0});
    send_vector('{16'sd0, 16'sh8000, 16'sd0});
    send_vector('{16'sd0, 16'sd0, 16'sd1});
    send_vector('{-16'sd1, 16'sd0, 16'sd0});
    send_vector('{16'sh8000, 16'sh8000, 16'sh8000});
    send_vector('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_vector('{16'sh7fff, 16'sh8000, 16'sd1});
    send_vector('{16'sd1, 16'sd1, 16'sd1});
    send_vector('{16'sd3, 16'sd4, 16'sd0});
    send_vector('{16'shffff, 16'sh5555, 16'shaaaa});
    for (int i = 0; i < 6; i++)
      send_vector('{ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6]});
  endtask

  task automatic test_random(int count);
    repeat (count) send_vector('{rand_component(), rand_component(), rand_component()});
  endtask

  // Pause the sender until the pipeline has fully drained, then send 20 random vectors.
  task automatic test_drain_pause();
    idle_sender();
    wait (pending_units.size() == 0);
    test_random(20);
  endtask

  // Receiver stall pattern: random stall holds separated by random gaps.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (checker_on && $urandom_range(1)) begin
        hold = $urandom_range(12);
        if (hold > 0) begin
          unit_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          unit_stall <= 1'b0;
        end
        repeat ($urandom_range(12)) @(posedge clk);
      end
    end
  end

  // Compare each accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && unit_valid && !unit_stall) begin
      if (pending_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", unit);
      end else begin
        nvec_pkg::unit_t want;
        want = pending_units.pop_front();
        if (unit !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, unit);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if ((vec_valid && !vec_stall) || (unit_valid && !unit_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    checker_on = 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_drain_pause();
    test_random(810);
    idle_sender();
    wait (pending_units.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_units.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
